// ----- sv/clx_pkg.sv -----
// ----------------------------------------------------------------------------
// clx_pkg
// Types and constants shared by the token lexer modules.
// ----------------------------------------------------------------------------
package clx_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [31:0] token_start;
      logic [31:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_STR  = 3'd1,
      MODE_NUM  = 3'd2,
      MODE_WORD = 3'd3,
      MODE_EQ   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_KEYWORD   = 3'd0,
      KIND_OPERATOR  = 3'd1,
      KIND_SEPARATOR = 3'd2,
      KIND_STRING    = 3'd3,
      KIND_NUMBER    = 3'd4,
      KIND_IDENT     = 3'd5,
      KIND_UNKNOWN   = 3'd6,
      KIND_EOF       = 3'd7
   } kind_type;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_EQ         = 8'h3D;

   localparam logic [47:0] KW_IF     = 48'h6966;
   localparam logic [47:0] KW_ELSE   = 48'h656C7365;
   localparam logic [47:0] KW_WHILE  = 48'h7768696C65;
   localparam logic [47:0] KW_FOR    = 48'h666F72;
   localparam logic [47:0] KW_RETURN = 48'h72657475726E;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

endpackage

// ----- sv/clx_scan.sv -----
// ----------------------------------------------------------------------------
// clx_scan
// Scanner state and single-pass token logic; up to two results per byte.
// ----------------------------------------------------------------------------
module clx_scan #(
   parameter int POS_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_fire,
   input  clx_pkg::req_type item,
   output logic [1:0]       res_count,
   output clx_pkg::rsp_type res0,
   output clx_pkg::rsp_type res1
);
   import clx_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   start_ff, start_in;
   logic [31:0]            len_ff, len_in;
   logic [47:0]            prefix_ff, prefix_in;

   logic [7:0]  c;
   logic        is_space, is_digit, is_alpha, is_word_ch;
   logic [63:0] pos_ext, start_ext;
   logic [31:0] len_grow;
   logic        keyword;

   logic        close_emit;
   rsp_type     close_rsp;
   logic        start_emit;
   rsp_type     start_rsp;
   mode_type    st_mode;
   logic [POS_WIDTH-1:0] st_start;
   logic [31:0] st_len;
   logic [47:0] st_prefix;
   logic        do_close_start;

   always_comb begin
      c          = item.char_in;
      is_space   = c inside {8'h20, [8'h09:8'h0D]};
      is_digit   = c inside {[8'h30:8'h39]};
      is_alpha   = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
      is_word_ch = is_alpha || is_digit || (c == CH_UNDERSCORE);
      pos_ext    = 64'(pos_ff);
      start_ext  = 64'(start_ff);
      len_grow   = (len_ff == 32'hFFFF_FFFF) ? len_ff : len_ff + 32'd1;
      keyword    = (len_ff == 32'd2 && prefix_ff == KW_IF)
                || (len_ff == 32'd4 && prefix_ff == KW_ELSE)
                || (len_ff == 32'd5 && prefix_ff == KW_WHILE)
                || (len_ff == 32'd3 && prefix_ff == KW_FOR)
                || (len_ff == 32'd6 && prefix_ff == KW_RETURN);

      // token closed by the open state
      close_rsp             = '0;
      close_rsp.token_start = start_ext[31:0];
      close_rsp.token_length = len_ff;
      close_emit            = 1'b1;
      case (mode_ff)
         MODE_STR:  close_rsp.token_kind = KIND_STRING;
         MODE_NUM:  close_rsp.token_kind = KIND_NUMBER;
         MODE_WORD: close_rsp.token_kind = keyword ? KIND_KEYWORD : KIND_IDENT;
         MODE_EQ: begin
            close_rsp.token_kind   = KIND_OPERATOR;
            close_rsp.token_length = 32'd1;
         end
         default: close_emit = 1'b0;
      endcase

      // byte scanned from idle
      start_rsp              = '0;
      start_rsp.token_start  = pos_ext[31:0];
      start_rsp.token_length = 32'd1;
      start_emit             = 1'b0;
      st_mode                = MODE_IDLE;
      st_start               = pos_ff;
      st_len                 = 32'd1;
      st_prefix              = prefix_ff;
      if (is_space) begin
         st_len = len_ff;
      end else if (c == CH_QUOTE) begin
         st_mode  = MODE_STR;
         st_start = pos_ff + POS_WIDTH'(1);
         st_len   = 32'd0;
      end else if (is_digit) begin
         st_mode = MODE_NUM;
      end else if (is_alpha || c == CH_UNDERSCORE) begin
         st_mode   = MODE_WORD;
         st_prefix = 48'(c);
      end else if (c == CH_EQ) begin
         st_mode = MODE_EQ;
      end else begin
         start_emit = 1'b1;
         if (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F}) begin
            start_rsp.token_kind = KIND_OPERATOR;
         end else if (c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B}) begin
            start_rsp.token_kind = KIND_SEPARATOR;
         end else begin
            start_rsp.token_kind = KIND_UNKNOWN;
         end
      end

      mode_in        = mode_ff;
      pos_in         = pos_ff;
      start_in       = start_ff;
      len_in         = len_ff;
      prefix_in      = prefix_ff;
      res_count      = 2'd0;
      res0           = '0;
      res1           = '0;
      do_close_start = 1'b0;

      if (item.cmd == CMD_END) begin
         res1.token_kind  = KIND_EOF;
         res1.token_start = pos_ext[31:0];
         if (close_emit) begin
            res0      = close_rsp;
            res_count = 2'd2;
         end else begin
            res0      = res1;
            res_count = 2'd1;
         end
         mode_in = MODE_IDLE;
         pos_in  = '0;
      end else begin
         pos_in = pos_ff + POS_WIDTH'(1);
         case (mode_ff)
            MODE_STR: begin
               if (c == CH_QUOTE) begin
                  res0      = close_rsp;
                  res_count = 2'd1;
                  mode_in   = MODE_IDLE;
               end else begin
                  len_in = len_grow;
               end
            end
            MODE_NUM: begin
               if (is_digit || c == CH_DOT) begin
                  len_in = len_grow;
               end else begin
                  do_close_start = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_word_ch) begin
                  len_in    = len_grow;
                  prefix_in = {prefix_ff[39:0], c};
               end else begin
                  do_close_start = 1'b1;
               end
            end
            MODE_EQ: begin
               if (c == CH_EQ) begin
                  res0.token_kind   = KIND_OPERATOR;
                  res0.token_start  = start_ext[31:0];
                  res0.token_length = 32'd2;
                  res_count         = 2'd1;
                  mode_in           = MODE_IDLE;
               end else begin
                  do_close_start = 1'b1;
               end
            end
            default: begin
               res0      = start_rsp;
               res_count = {1'b0, start_emit};
               mode_in   = st_mode;
               start_in  = st_start;
               len_in    = st_len;
               prefix_in = st_prefix;
            end
         endcase
         if (do_close_start) begin
            res0      = close_rsp;
            res1      = start_rsp;
            res_count = start_emit ? 2'd2 : 2'd1;
            mode_in   = st_mode;
            start_in  = st_start;
            len_in    = st_len;
            prefix_in = st_prefix;
         end
      end
      res0.last_of_run = (res_count == 2'd1);
      res1.last_of_run = (res_count == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
      end else if (item_fire) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         start_ff  <= start_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

// ----- sv/clx_rsp_fifo.sv -----
// ----------------------------------------------------------------------------
// clx_rsp_fifo
// Result queue: takes zero, one or two results a cycle, delivers one.
// ----------------------------------------------------------------------------
module clx_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  clx_pkg::rsp_type push0,
   input  clx_pkg::rsp_type push1,
   output logic             room_two,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output clx_pkg::rsp_type rsp_data
);
   import clx_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   logic [RSP_PTR_W-1:0]   wr_next;

   always_comb begin
      rsp_valid = (count_ff != '0);
      rsp_data  = mem_ff[rd_ptr_ff];
      room_two  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
      pop       = rsp_valid && rsp_ready;
      wr_next   = wr_ptr_ff + RSP_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

endmodule

// ----- sv/c_like_token_lexer_core.sv -----
// ----------------------------------------------------------------------------
// c_like_token_lexer_core
// Streaming lexer for C-like source text; reports tokens as kind, start
// offset and length.
// ----------------------------------------------------------------------------
// The block takes one source byte (or an end-of-input marker) per cycle and
// produces tokens one per cycle on the result channel. A byte is held in an
// input register, scanned, and its results are written into a four-entry
// result queue. The byte waits in the input register until two queue entries
// are free; its first result is valid once written into the queue. A byte
// that closes one token and emits another (and the end
// marker after an open token) yields two results; the queue drains one per
// cycle and a byte is scanned only while two queue entries are free, so the
// rate is one byte per cycle as long as the result side keeps up and on
// average no more than one token per byte is produced.
module c_like_token_lexer_core #(
   parameter int POS_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  clx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output clx_pkg::rsp_type rsp_data
);
   import clx_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_ff;
   logic     room_two;
   logic     scan_fire;
   logic     req_fire;
   logic [1:0] res_count;
   logic [1:0] push_count;
   rsp_type  res0, res1;

   always_comb begin
      scan_fire   = in_valid_ff && room_two;
      req_ready   = !in_valid_ff || scan_fire;
      req_fire    = req_valid && req_ready;
      in_valid_in = req_fire || (in_valid_ff && !scan_fire);
      push_count  = scan_fire ? res_count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_data;
      end
   end

   clx_scan #(
      .POS_WIDTH (POS_WIDTH)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .item_fire (scan_fire),
      .item      (in_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   clx_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .room_two   (room_two),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C-like token lexer.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes comes first. Some of its rows carry the
// tokens they must produce. Then random texts follow: keywords, near-keywords,
// identifiers, numbers, strings, operators, separators, blanks and stray bytes,
// each text closed by an end marker. Every accepted byte runs through a
// scanner model kept in the bench. The tokens it predicts (or the ones a row
// carries) are queued and compared field by field with what the core returns.
// Both channels idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb;
   import clx_pkg::*;

   typedef struct packed {
      req_type   req;
      logic [1:0] nfix;
      rsp_type   fix0;
      rsp_type   fix1;
   } stim_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  ch;
      logic [1:0]  nfix;
      logic [2:0]  k0;
      logic [31:0] s0;
      logic [31:0] l0;
      logic [2:0]  k1;
      logic [31:0] s1;
      logic [31:0] l1;
   } dir_row_type;

   localparam int DIR_ROWS = 26;
   localparam int RAND_ITEMS = 1950;
   localparam int TAIL = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   c_like_token_lexer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // hand-picked bytes; rows with nfix > 0 carry their tokens
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{CMD_BYTE, "(",   1, KIND_SEPARATOR, 0, 1, 0, 0, 0},
      '{CMD_BYTE, 8'hFF, 1, KIND_UNKNOWN, 1, 1, 0, 0, 0},
      '{CMD_BYTE, 8'h00, 1, KIND_UNKNOWN, 2, 1, 0, 0, 0},
      '{CMD_BYTE, "=",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "=",   1, KIND_OPERATOR, 3, 2, 0, 0, 0},
      '{CMD_BYTE, "=",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "i",   1, KIND_OPERATOR, 5, 1, 0, 0, 0},
      '{CMD_BYTE, "f",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, " ",   1, KIND_KEYWORD, 6, 2, 0, 0, 0},
      '{CMD_BYTE, CH_QUOTE, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, CH_QUOTE, 1, KIND_STRING, 10, 0, 0, 0, 0},
      '{CMD_BYTE, "9",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, CH_DOT, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "0",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "+",   2, KIND_NUMBER, 11, 3, KIND_OPERATOR, 14, 1},
      '{CMD_BYTE, CH_UNDERSCORE, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "x",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, 8'h09, 1, KIND_IDENT, 15, 2, 0, 0, 0},
      '{CMD_BYTE, CH_QUOTE, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "a",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_END,  8'hA5, 2, KIND_STRING, 19, 1, KIND_EOF, 20, 0},
      '{CMD_BYTE, "f",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "o",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, "r",   0, 0, 0, 0, 0, 0, 0},
      '{CMD_BYTE, ";",   2, KIND_KEYWORD, 0, 3, KIND_SEPARATOR, 3, 1},
      '{CMD_END,  8'h5A, 1, KIND_EOF, 4, 0, 0, 0, 0}
   };

   string kw_words [5] = '{"if", "else", "while", "for", "return"};
   string near_words [6] = '{"returns", "whiles", "iff", "_if", "If", "elsewhere"};
   string op_words [7] = '{"+", "-", "*", "/", "=", "==", "==="};
   string sep_chars = "(){};";

   stim_type stim_q [$];
   rsp_type  pending_tokens [$];

   // scanner state mirrored in the bench
   mode_type    lx_mode = MODE_IDLE;
   logic [31:0] lx_pos = '0;
   logic [31:0] lx_start = '0;
   logic [31:0] lx_len = '0;
   logic [47:0] lx_prefix = '0;
   rsp_type     lx_out [2];
   int          lx_n;

   int mismatches = 0;
   int tokens_seen = 0;
   int texts_sent = 0;
   int next_idx = 0;
   int items_done = 0;
   int gap_left = 0;
   int gap_pct = 0;
   int stall_left = 0;
   int stall_pct = 0;
   stim_type cur_item;

   function automatic logic is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void emit(logic [2:0] k, logic [31:0] s, logic [31:0] l);
      lx_out[lx_n] = '{token_kind: k, token_start: s, token_length: l, last_of_run: 1'b0};
      lx_n++;
   endfunction

   function automatic void grow();
      if (lx_len != 32'hFFFF_FFFF) lx_len++;
   endfunction

   function automatic logic is_keyword();
      return (lx_len == 2 && lx_prefix == KW_IF) || (lx_len == 4 && lx_prefix == KW_ELSE) ||
             (lx_len == 5 && lx_prefix == KW_WHILE) || (lx_len == 3 && lx_prefix == KW_FOR) ||
             (lx_len == 6 && lx_prefix == KW_RETURN);
   endfunction

   function automatic void close_token();
      mode_type m;
      m = lx_mode;
      lx_mode = MODE_IDLE;
      case (m)
         MODE_STR:  emit(KIND_STRING, lx_start, lx_len);
         MODE_NUM:  emit(KIND_NUMBER, lx_start, lx_len);
         MODE_WORD: emit(is_keyword() ? KIND_KEYWORD : KIND_IDENT, lx_start, lx_len);
         MODE_EQ:   emit(KIND_OPERATOR, lx_start, 32'd1);
         default: ;
      endcase
   endfunction

   function automatic void scan_fresh(logic [7:0] c, logic [31:0] pos);
      lx_mode = MODE_IDLE;
      if (is_blank(c)) begin
         return;
      end else if (c == CH_QUOTE) begin
         lx_mode = MODE_STR;
         lx_start = pos + 1;
         lx_len = 0;
      end else if (is_digit_ch(c)) begin
         lx_mode = MODE_NUM;
         lx_start = pos;
         lx_len = 1;
      end else if (is_letter(c) || c == CH_UNDERSCORE) begin
         lx_mode = MODE_WORD;
         lx_start = pos;
         lx_len = 1;
         lx_prefix = {40'd0, c};
      end else if (c == CH_EQ) begin
         lx_mode = MODE_EQ;
         lx_start = pos;
         lx_len = 1;
      end else if (c inside {"+", "-", "*", "/"}) begin
         emit(KIND_OPERATOR, pos, 32'd1);
      end else if (c inside {"(", ")", "{", "}", ";"}) begin
         emit(KIND_SEPARATOR, pos, 32'd1);
      end else begin
         emit(KIND_UNKNOWN, pos, 32'd1);
      end
   endfunction

   // scan one accepted transfer and queue the tokens it must produce
   function automatic void lex_byte(stim_type it);
      logic [31:0] pos;
      logic [7:0]  c;
      lx_n = 0;
      pos = lx_pos;
      c = it.req.char_in;
      if (it.req.cmd == CMD_END) begin
         close_token();
         emit(KIND_EOF, pos, 32'd0);
         lx_mode = MODE_IDLE;
         lx_pos = '0;
         lx_start = '0;
         lx_len = '0;
         lx_prefix = '0;
      end else begin
         case (lx_mode)
            MODE_STR: begin
               if (c == CH_QUOTE) close_token();
               else grow();
            end
            MODE_NUM: begin
               if (is_digit_ch(c) || c == CH_DOT) begin
                  grow();
               end else begin
                  close_token();
                  scan_fresh(c, pos);
               end
            end
            MODE_WORD: begin
               if (is_letter(c) || is_digit_ch(c) || c == CH_UNDERSCORE) begin
                  grow();
                  lx_prefix = {lx_prefix[39:0], c};
               end else begin
                  close_token();
                  scan_fresh(c, pos);
               end
            end
            MODE_EQ: begin
               if (c == CH_EQ) begin
                  emit(KIND_OPERATOR, lx_start, 32'd2);
                  lx_mode = MODE_IDLE;
               end else begin
                  close_token();
                  scan_fresh(c, pos);
               end
            end
            default: scan_fresh(c, pos);
         endcase
         lx_pos = pos + 1;
      end
      if (lx_n > 0) lx_out[lx_n - 1].last_of_run = 1'b1;
      if (it.nfix != 0) begin
         pending_tokens = {pending_tokens, it.fix0};
         if (it.nfix == 2) pending_tokens = {pending_tokens, it.fix1};
      end else begin
         for (int i = 0; i < lx_n; i++) pending_tokens = {pending_tokens, lx_out[i]};
      end
   endfunction

   task automatic add_byte(logic [7:0] c);
      stim_type e;
      e = '0;
      e.req.cmd = CMD_BYTE;
      e.req.char_in = c;
      stim_q = {stim_q, e};
   endtask

   task automatic add_word(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] blank_byte();
      int r;
      r = $urandom_range(5);
      return (r == 5) ? 8'h20 : 8'(8'h09 + r);
   endfunction

   function automatic logic [7:0] word_byte(logic lead);
      int r;
      r = lead ? $urandom_range(52) : $urandom_range(62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + (r - 26));
      if (r == 52) return CH_UNDERSCORE;
      return 8'("0" + (r - 53));
   endfunction

   function automatic logic [7:0] str_byte();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      return (c == CH_QUOTE) ? 8'h21 : c;
   endfunction

   task automatic add_fragment();
      int r;
      r = $urandom_range(19);
      if (r <= 2) begin
         add_word(kw_words[$urandom_range(4)]);
      end else if (r == 3) begin
         add_word(near_words[$urandom_range(5)]);
      end else if (r <= 6) begin
         add_byte(word_byte(1'b1));
         repeat ($urandom_range(9)) add_byte(word_byte(1'b0));
      end else if (r <= 9) begin
         add_byte(8'("0" + $urandom_range(9)));
         repeat ($urandom_range(6))
            add_byte(($urandom_range(3) == 0) ? CH_DOT : 8'("0" + $urandom_range(9)));
      end else if (r <= 11) begin
         add_byte(CH_QUOTE);
         repeat ($urandom_range(8)) add_byte(str_byte());
         add_byte(CH_QUOTE);
      end else if (r <= 13) begin
         add_word(op_words[$urandom_range(6)]);
      end else if (r <= 15) begin
         add_byte(sep_chars[$urandom_range(4)]);
      end else if (r <= 17) begin
         add_byte(blank_byte());
      end else begin
         add_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic add_text();
      stim_type e;
      repeat ($urandom_range(14)) begin
         add_fragment();
         if ($urandom_range(1) == 1) add_byte(blank_byte());
      end
      // unterminated string before the end marker
      if ($urandom_range(9) == 0) begin
         add_byte(CH_QUOTE);
         repeat ($urandom_range(3)) add_byte(str_byte());
      end
      e = '0;
      e.req.cmd = CMD_END;
      e.req.char_in = 8'($urandom_range(255));
      stim_q = {stim_q, e};
   endtask

   // source side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            lex_byte(cur_item);
            if (cur_item.req.cmd == CMD_END) texts_sent++;
            items_done++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (next_idx < stim_q.size()) begin
            cur_item = stim_q[next_idx];
            next_idx++;
            req_valid <= 1'b1;
            req_data <= cur_item.req;
            if (next_idx % 100 == 0) gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 5);
            if (next_idx < stim_q.size() - TAIL && $urandom_range(99) < gap_pct)
               gap_left = $urandom_range(11, 1);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // token side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            tokens_seen++;
            if (pending_tokens.size() == 0) begin
               $error("token transfer with nothing expected: kind %0d start %0d length %0d",
                      rsp_data.token_kind, rsp_data.token_start, rsp_data.token_length);
               mismatches++;
            end else begin
               rsp_type want;
               want = pending_tokens.pop_front();
               if (rsp_data.token_kind !== want.token_kind) begin
                  $error("token_kind: expected %0d, got %0d", want.token_kind, rsp_data.token_kind);
                  mismatches++;
               end
               if (rsp_data.token_start !== want.token_start) begin
                  $error("token_start: expected %0d, got %0d",
                         want.token_start, rsp_data.token_start);
                  mismatches++;
               end
               if (rsp_data.token_length !== want.token_length) begin
                  $error("token_length: expected %0d, got %0d",
                         want.token_length, rsp_data.token_length);
                  mismatches++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d",
                         want.last_of_run, rsp_data.last_of_run);
                  mismatches++;
               end
            end
            if (tokens_seen % 64 == 0)
               stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 5);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (next_idx < stim_q.size() - TAIL && $urandom_range(99) < stall_pct)
               stall_left = $urandom_range(11, 1);
         end
      end
   end

   initial begin
      stim_type e;
      int waited;
      for (int i = 0; i < DIR_ROWS; i++) begin
         e = '0;
         e.req.cmd = dir_rows[i].cmd;
         e.req.char_in = dir_rows[i].ch;
         e.nfix = dir_rows[i].nfix;
         e.fix0 = '{dir_rows[i].k0, dir_rows[i].s0, dir_rows[i].l0, dir_rows[i].nfix == 1};
         e.fix1 = '{dir_rows[i].k1, dir_rows[i].s1, dir_rows[i].l1, 1'b1};
         stim_q = {stim_q, e};
      end
      while (stim_q.size() < DIR_ROWS + RAND_ITEMS) add_text();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (items_done < stim_q.size()) @(posedge clock);
      waited = 0;
      while (pending_tokens.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending_tokens.size() != 0) begin
         $error("%0d expected tokens never arrived", pending_tokens.size());
         mismatches++;
      end

      $display("covered %0d source transfers in %0d texts, %0d tokens compared",
               items_done, texts_sent, tokens_seen);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
